[sv/vnte_pkg.sv]
package vnte_pkg;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] K_TOKEN = 2'd0;
    localparam logic [1:0] K_DONE  = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;
    localparam logic [1:0] K_REST  = 2'd3;

    // Characters with a fixed meaning.
    localparam logic [7:0] CH_ESC   = 8'h5C;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_OPEN_SEP  = 2'd0;
    localparam logic [1:0] REG_CLOSE_SEP = 2'd1;
    localparam logic [1:0] REG_MAX_LEN   = 2'd2;

    // Register reset values.
    localparam logic [7:0]  OPEN_SEP_RST  = 8'd91;
    localparam logic [7:0]  CLOSE_SEP_RST = 8'd93;
    localparam logic [15:0] MAX_LEN_RST   = 16'd0;

endpackage

[sv/validated_nested_token_extractor.sv]
// Nested token extractor with bracket validation.
// The slave-side stream takes one string character per beat in s_tdata[7:0], with
// s_tlast marking the final character of a string. Leading spaces are skipped and
// one optional open separator is consumed, then the token is read with one level
// open. Parentheses and the configured separators nest on a bit stack of up to
// MAX_NEST levels, and a backslash escapes the next character.
// The master-side stream carries at most one result per input beat: m_tuser holds
// the kind (token character, closed ok, error, remainder character), m_tdata holds
// the character and the count of held-back spaces to insert before it.
// The APB port sets the open separator, the close separator and the token length
// limit; write it only while the block is idle: the block does not enforce this.
// A beat is taken into an input register and processed from there; its result
// is registered into the result register when the item advances, which a stall
// of the receiver can hold back. One beat is accepted in every cycle while the
// receiver does not stall; the only loop is the update of the parse state.
// When the receiver stalls, the result register holds its beat and the input
// register fills; s_tready drops only when both are occupied.
// Reset clears the parse state to the start of a string, empties both registers
// and restores the register defaults.
module validated_nested_token_extractor
    import vnte_pkg::*;
#(
    parameter int MAX_NEST = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave side: tdata = ch[7:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // Master side: tdata = out_char[7:0], lead_spaces[15:8]; tuser = kind[1:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 2);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_TOKEN,
        PH_REST_SKIP,
        PH_REST
    } phase_t;

    // Configuration registers.
    logic [7:0]  open_sep_reg;
    logic [7:0]  close_sep_reg;
    logic [15:0] max_len_reg;
    logic        cfg_wr;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;
    logic        advance;

    // Parse state.
    phase_t              phase_reg,   phase_next;
    logic [DEPTH_W-1:0]  depth_reg,   depth_next;
    logic [MAX_NEST-1:0] stack_reg,   stack_next;
    logic                esc_reg,     esc_next;
    logic [7:0]          held_reg,    held_next;
    logic [15:0]         emitted_reg, emitted_next;

    // Result register.
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_char_reg;
    logic [7:0]  out_lead_reg;

    // Result of the current item.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_char;
    logic [7:0]  res_lead;

    // Bracket classification of the current character.
    logic                is_lpar, is_rpar, is_open, is_close;
    logic                push, pop, mismatch, overflow, tok_fail;
    logic [DEPTH_W-1:0]  depth_inc, depth_upd;
    logic [MAX_NEST-1:0] stack_upd;
    logic                esc_new;
    logic                run_token;

    // Delivery of token characters with held spaces and truncation.
    logic        is_space;
    logic [7:0]  held_inc;
    logic        budget_on, budget_full, lead_fills;
    logic [15:0] rem, rem_m1;
    logic [16:0] emit_sum;
    logic [15:0] emit_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_OPEN_SEP:  prdata = {24'd0, open_sep_reg};
            REG_CLOSE_SEP: prdata = {24'd0, close_sep_reg};
            REG_MAX_LEN:   prdata = {16'd0, max_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // An item moves on when the result register is free or is being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lead_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;

    // The escape flag masks all four bracket tests; the tests are ordered, so a
    // separator that equals a parenthesis acts as the parenthesis.
    assign is_lpar  = !esc_reg && (in_ch_reg == CH_LPAR);
    assign is_rpar  = !esc_reg && !is_lpar && (in_ch_reg == CH_RPAR);
    assign is_open  = !esc_reg && !is_lpar && !is_rpar && (in_ch_reg == open_sep_reg);
    assign is_close = !esc_reg && !is_lpar && !is_rpar && !is_open
                      && (in_ch_reg == close_sep_reg);

    assign push      = is_lpar || is_open;
    assign pop       = is_rpar || is_close;
    assign mismatch  = (is_rpar && stack_reg[0]) || (is_close && !stack_reg[0]);
    assign depth_inc = depth_reg + DEPTH_W'(1);
    assign overflow  = push && (depth_inc > DEPTH_W'(MAX_NEST));
    assign tok_fail  = mismatch || overflow;

    always_comb
    begin
        if (push)
        begin
            depth_upd = depth_inc;
            stack_upd = {stack_reg[MAX_NEST-2:0], is_open};
        end
        else if (pop && !mismatch)
        begin
            depth_upd = depth_reg - DEPTH_W'(1);
            stack_upd = stack_reg >> 1;
        end
        else
        begin
            depth_upd = depth_reg;
            stack_upd = stack_reg;
        end
    end

    assign esc_new = (in_ch_reg == CH_ESC) && !esc_reg;

    assign is_space    = (in_ch_reg == CH_SPACE);
    assign held_inc    = (held_reg == 8'hFF) ? held_reg : held_reg + 8'd1;
    assign budget_on   = (max_len_reg != 16'd0);
    assign budget_full = (emitted_reg >= max_len_reg);
    assign rem         = max_len_reg - emitted_reg;
    assign rem_m1      = rem - 16'd1;
    assign lead_fills  = ({8'd0, held_reg} >= rem);
    assign emit_sum    = {1'b0, emitted_reg} + {9'd0, held_reg} + 17'd1;
    assign emit_sat    = emit_sum[16] ? 16'hFFFF : emit_sum[15:0];

    always_comb
    begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        stack_next   = stack_reg;
        esc_next     = esc_reg;
        held_next    = held_reg;
        emitted_next = emitted_reg;
        res_valid    = 1'b0;
        res_kind     = K_TOKEN;
        res_char     = 8'd0;
        res_lead     = 8'd0;
        run_token    = 1'b0;

        case (phase_reg)
            PH_LEAD:
            begin
                // The first non-space character starts the token; an open
                // separator here is the outer level, which is already open.
                if (!is_space)
                begin
                    phase_next = PH_TOKEN;
                    run_token  = (in_ch_reg != open_sep_reg);
                end
            end
            PH_TOKEN:
            begin
                run_token = 1'b1;
            end
            PH_REST_SKIP:
            begin
                if (!is_space)
                begin
                    phase_next = PH_REST;
                    res_valid  = 1'b1;
                    res_kind   = K_REST;
                    res_char   = in_ch_reg;
                end
            end
            PH_REST:
            begin
                // A nonzero depth here means an error was seen: discard.
                if (depth_reg == '0)
                begin
                    res_valid = 1'b1;
                    res_kind  = K_REST;
                    res_char  = in_ch_reg;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (run_token)
        begin
            depth_next = depth_upd;
            stack_next = stack_upd;
            if (tok_fail)
            begin
                phase_next = PH_REST;
                res_valid  = 1'b1;
                res_kind   = K_ERROR;
            end
            else
            begin
                esc_next = esc_new;
                if (depth_upd == '0)
                begin
                    // The outer level closed: the token is complete and any
                    // trailing spaces are dropped.
                    phase_next = PH_REST_SKIP;
                    held_next  = 8'd0;
                    res_valid  = 1'b1;
                    res_kind   = K_DONE;
                end
                else if (!esc_new)
                begin
                    if (is_space)
                    begin
                        held_next = held_inc;
                    end
                    else
                    begin
                        held_next = 8'd0;
                        if (budget_on && budget_full)
                        begin
                            res_valid = 1'b0;
                        end
                        else if (budget_on && lead_fills)
                        begin
                            // The held spaces use up the rest of the budget.
                            emitted_next = max_len_reg;
                            res_valid    = 1'b1;
                            res_kind     = K_TOKEN;
                            res_char     = CH_SPACE;
                            res_lead     = rem_m1[7:0];
                        end
                        else
                        begin
                            emitted_next = emit_sat;
                            res_valid    = 1'b1;
                            res_kind     = K_TOKEN;
                            res_char     = in_ch_reg;
                            res_lead     = held_reg;
                        end
                    end
                end
            end
        end

        if (in_last_reg)
        begin
            // A string that ends with the token still open is an error, which
            // replaces any other result of this character.
            if (phase_next == PH_LEAD || phase_next == PH_TOKEN)
            begin
                res_valid = 1'b1;
                res_kind  = K_ERROR;
                res_char  = 8'd0;
                res_lead  = 8'd0;
            end
            phase_next   = PH_LEAD;
            depth_next   = DEPTH_W'(1);
            stack_next   = MAX_NEST'(1);
            esc_next     = 1'b0;
            held_next    = 8'd0;
            emitted_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_sep_reg  <= OPEN_SEP_RST;
            close_sep_reg <= CLOSE_SEP_RST;
            max_len_reg   <= MAX_LEN_RST;
            in_valid_reg  <= 1'b0;
            in_ch_reg     <= 8'd0;
            in_last_reg   <= 1'b0;
            phase_reg     <= PH_LEAD;
            depth_reg     <= DEPTH_W'(1);
            stack_reg     <= MAX_NEST'(1);
            esc_reg       <= 1'b0;
            held_reg      <= 8'd0;
            emitted_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= K_TOKEN;
            out_char_reg  <= 8'd0;
            out_lead_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_OPEN_SEP:  open_sep_reg  <= pwdata[7:0];
                    REG_CLOSE_SEP: close_sep_reg <= pwdata[7:0];
                    REG_MAX_LEN:   max_len_reg   <= pwdata[15:0];
                    default:       max_len_reg   <= max_len_reg;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_ch_reg    <= s_tdata;
                in_last_reg  <= s_tlast;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                depth_reg     <= depth_next;
                stack_reg     <= stack_next;
                esc_reg       <= esc_next;
                held_reg      <= held_next;
                emitted_reg   <= emitted_next;
                out_valid_reg <= res_valid;
                out_kind_reg  <= res_kind;
                out_char_reg  <= res_char;
                out_lead_reg  <= res_lead;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/vnte_checker.sv]
module vnte_checker
    import vnte_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Completion and error beats carry no character and no spaces.
    a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_DONE || m_tuser == K_ERROR) |-> m_tdata == 16'd0)
        else $error("status beat carries data");

    // Remainder beats never carry held spaces.
    a_rest_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_REST |-> m_tdata[15:8] == 8'd0)
        else $error("remainder beat carries spaces");

    // With the result register empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind validated_nested_token_extractor vnte_checker u_vnte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb_validated_nested_token_extractor.sv]
module tb_validated_nested_token_extractor;
    import vnte_pkg::*;

    // Nesting limit of the instance; the predictor uses the same value.
    localparam int NEST_LIMIT = 64;

    // Longest deliberate receiver hold, in cycles.
    localparam int HOLD_CYCLES = 300;

    // Cycles without any beat on either stream before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold above plus one run of a
    // stall mode, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;

    // Rough input budget. The random part runs until the total beat count reaches
    // RANDOM_TARGET, and the back-pressure test adds about PRESSURE_BEATS on top.
    localparam int RANDOM_TARGET  = 1000;
    localparam int PRESSURE_BEATS = 150;

    // Phases of the string parser, as tracked by the predictor.
    typedef enum logic [1:0]
    {
        SKIP_LEAD,
        IN_TOKEN,
        SKIP_REST,
        PASS_REST
    } parse_phase_t;

    // One result beat, split into its fields.
    typedef struct packed
    {
        logic [1:0] kind;
        logic [7:0] chr;
        logic [7:0] lead;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    validated_nested_token_extractor #(
        .MAX_NEST (NEST_LIMIT)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the configuration registers, updated at the write edge.
    logic [7:0]  cfg_open = OPEN_SEP_RST;
    logic [7:0]  cfg_close = CLOSE_SEP_RST;
    logic [15:0] cfg_max_len = MAX_LEN_RST;

    // Predictor state for the string that is currently being parsed.
    parse_phase_t ps_phase;
    logic [6:0]   ps_depth;
    logic [63:0]  ps_stack;
    bit           ps_escape;
    logic [7:0]   ps_held;
    logic [15:0]  ps_emitted;

    // Results that the block owes us, oldest first.
    parse_result_t pending_results[$];

    // Characters of the next string to send.
    logic [7:0] text_q[$];

    int  beats_sent = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  burst_left = 0;
    bit  no_gaps = 1'b0;
    int  holds_requested = 0;

    // Back to the start of a string. Called at reset and after every last beat.
    function automatic void parser_restart();
        ps_phase   = SKIP_LEAD;
        ps_depth   = 7'd1;
        ps_stack   = 64'd1;
        ps_escape  = 1'b0;
        ps_held    = '0;
        ps_emitted = '0;
    endfunction

    // One character inside the token: nesting, escape, held spaces and the
    // length budget. Returns 1 when the character produces a result.
    function automatic bit scan_token_char(input logic [7:0] c, output parse_result_t r);
        bit was_escaped;
        int lead;
        int room;
        int total;
        r = '0;
        was_escaped = ps_escape;
        if (!was_escaped)
        begin
            // Parentheses are checked before the configured separators, so a
            // separator set to a parenthesis never acts as a separator.
            if (c == CH_LPAR)
            begin
                ps_stack = ps_stack << 1;
                ps_depth++;
                if (ps_depth > NEST_LIMIT)
                begin
                    ps_phase = PASS_REST;
                    r.kind = K_ERROR;
                    return 1'b1;
                end
            end
            else if (c == CH_RPAR)
            begin
                if (ps_stack[0])
                begin
                    ps_phase = PASS_REST;
                    r.kind = K_ERROR;
                    return 1'b1;
                end
                ps_stack = ps_stack >> 1;
                ps_depth--;
            end
            else if (c == cfg_open)
            begin
                ps_stack = (ps_stack << 1) | 64'd1;
                ps_depth++;
                if (ps_depth > NEST_LIMIT)
                begin
                    ps_phase = PASS_REST;
                    r.kind = K_ERROR;
                    return 1'b1;
                end
            end
            else if (c == cfg_close)
            begin
                if (!ps_stack[0])
                begin
                    ps_phase = PASS_REST;
                    r.kind = K_ERROR;
                    return 1'b1;
                end
                ps_stack = ps_stack >> 1;
                ps_depth--;
            end
        end
        // An opener that is also the escape character still escapes the next one.
        ps_escape = (c == CH_ESC) && !was_escaped;
        if (ps_depth == 0)
        begin
            ps_phase = SKIP_REST;
            ps_held = '0;
            r.kind = K_DONE;
            return 1'b1;
        end
        if (ps_escape)
            return 1'b0;
        if (c == CH_SPACE)
        begin
            if (ps_held != 8'd255)
                ps_held++;
            return 1'b0;
        end
        lead = int'(ps_held);
        ps_held = '0;
        if (cfg_max_len != 0)
        begin
            if (ps_emitted >= cfg_max_len)
                return 1'b0;
            room = int'(cfg_max_len) - int'(ps_emitted);
            // The held spaces use up what is left of the budget: only spaces go out.
            if (lead >= room)
            begin
                ps_emitted = cfg_max_len;
                r.kind = K_TOKEN;
                r.chr  = CH_SPACE;
                r.lead = 8'(room - 1);
                return 1'b1;
            end
        end
        total = int'(ps_emitted) + lead + 1;
        ps_emitted = (total > 65535) ? 16'hFFFF : 16'(total);
        r.kind = K_TOKEN;
        r.chr  = c;
        r.lead = 8'(lead);
        return 1'b1;
    endfunction

    // Expected outcome of one accepted input beat.
    function automatic bit parse_char(input logic [7:0] c, input bit is_last,
                                      output parse_result_t r);
        bit got;
        got = 1'b0;
        r = '0;
        case (ps_phase)
            SKIP_LEAD:
                if (c != CH_SPACE)
                begin
                    ps_phase = IN_TOKEN;
                    // One leading open separator is swallowed; the outer level
                    // is already open.
                    if (c != cfg_open)
                        got = scan_token_char(c, r);
                end
            IN_TOKEN:
                got = scan_token_char(c, r);
            SKIP_REST:
                if (c != CH_SPACE)
                begin
                    ps_phase = PASS_REST;
                    r.kind = K_REST;
                    r.chr  = c;
                    got = 1'b1;
                end
            default:
                // A nonzero depth here means an error was seen: discard silently.
                if (ps_depth == 0)
                begin
                    r.kind = K_REST;
                    r.chr  = c;
                    got = 1'b1;
                end
        endcase
        if (is_last)
        begin
            // Ending with levels still open overrides whatever this beat produced.
            if (ps_phase == SKIP_LEAD || ps_phase == IN_TOKEN)
            begin
                r = '0;
                r.kind = K_ERROR;
                got = 1'b1;
            end
            parser_restart();
        end
        return got;
    endfunction

    function automatic void append(input string str);
        for (int i = 0; i < str.len(); i++)
            text_q.push_back(str[i]);
    endfunction

    // Builds one random string. Most strings are well formed with random
    // content; some are broken on purpose and some are plain noise.
    function automatic void make_random_text(input int body_max);
        bit         kinds[$];
        int         mode;
        int         pick;
        logic [7:0] c;
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 7))
                    0:       c = CH_LPAR;
                    1:       c = CH_RPAR;
                    2:       c = cfg_open;
                    3:       c = cfg_close;
                    4:       c = CH_ESC;
                    5:       c = CH_SPACE;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                text_q.push_back(c);
            end
            return;
        end
        repeat ($urandom_range(0, 3))
            text_q.push_back(CH_SPACE);
        if ($urandom_range(0, 3) != 0)
            text_q.push_back(cfg_open);
        repeat ($urandom_range(0, body_max))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
            else if (pick < 60)
                text_q.push_back(CH_SPACE);
            else if (pick < 68)
            begin
                text_q.push_back(CH_LPAR);
                kinds.push_back(1'b0);
            end
            else if (pick < 76)
            begin
                text_q.push_back(cfg_open);
                kinds.push_back(1'b1);
            end
            else if (pick < 88)
            begin
                if (kinds.size() != 0)
                    text_q.push_back(kinds.pop_back() ? cfg_close : CH_RPAR);
            end
            else if (pick < 94)
            begin
                text_q.push_back(CH_ESC);
                text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (mode < 20)
        begin
            // Broken: either a closer of the wrong kind, or the string just ends
            // with levels open.
            if ($urandom_range(0, 1) != 0)
            begin
                if (kinds.size() == 0 || kinds[$])
                    text_q.push_back(CH_RPAR);
                else
                    text_q.push_back(cfg_close);
                append("zz");
            end
            return;
        end
        while (kinds.size() != 0)
            text_q.push_back(kinds.pop_back() ? cfg_close : CH_RPAR);
        text_q.push_back(cfg_close);
        repeat ($urandom_range(0, 3))
            text_q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 5))
            text_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Sends one character. The sender works in bursts: at the start of each
    // burst it may drop tvalid for a random gap. tvalid stays high between
    // beats of a burst, so the next beat follows without a bubble.
    task automatic send_beat(input logic [7:0] c, input bit is_last);
        parse_result_t r;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        if (parse_char(c, is_last, r))
            pending_results.push_back(r);
    endtask

    // Sends the built string with tlast on its final character.
    task automatic send_text();
        if (text_q.size() == 0)
            text_q.push_back(8'h61);
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Stops offering beats and lets everything in flight drain. Beats that
    // give no result can still be inside the block when the last result
    // arrives, so the wait runs on past it to cover its two-stage pipeline.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OPEN_SEP:  cfg_open    = value[7:0];
            REG_CLOSE_SEP: cfg_close   = value[7:0];
            REG_MAX_LEN:   cfg_max_len = value[15:0];
            default:       ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] open_c, input logic [7:0] close_c,
                              input logic [15:0] max_len);
        wait_idle();
        write_reg(REG_OPEN_SEP, {24'd0, open_c});
        write_reg(REG_CLOSE_SEP, {24'd0, close_c});
        write_reg(REG_MAX_LEN, {16'd0, max_len});
    endtask

    // Reset settings: the basic shapes of a string, every result kind, escapes,
    // both kinds of mismatched closer, an unterminated string, the empty token
    // and the extreme byte values.
    task automatic test_directed();
        // Leading space, swallowed opener, parentheses, held spaces given
        // before a later character, and a remainder after skipped spaces.
        append(" [a (b)  c]  x");
        send_text();
        // Empty token.
        append("[]");
        send_text();
        // Separator closer meeting a parenthesis level.
        append("(]");
        send_text();
        // Escaped closer, then 0xFF and 0x00 as data, ending with the level open.
        append("\\]");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text();
        // Parenthesis closer meeting the outer separator level.
        append(")");
        send_text();
    endtask

    // Separator registers at their extremes and at odd values: the escape
    // character as opener, a letter for both, and the parentheses themselves.
    task automatic test_separators();
        logic [7:0] opens[6];
        logic [7:0] closes[6];
        opens  = '{8'h00, 8'hFF, CH_ESC, 8'h3C, 8'h61, CH_LPAR};
        closes = '{8'hFF, 8'h00, 8'h2F, 8'h3E, 8'h61, CH_RPAR};
        for (int i = 0; i < 6; i++)
        begin
            set_config(opens[i], closes[i], 16'd0);
            repeat (2)
            begin
                make_random_text(12);
                send_text();
            end
        end
    endtask

    // Token length budget, from one character up to the largest value, and a
    // run of spaces long enough to hit the 255 limit on held spaces.
    task automatic test_truncation();
        logic [15:0] limits[5];
        limits = '{16'd1, 16'd2, 16'd7, 16'hFFFF, 16'd0};
        for (int i = 0; i < 5; i++)
        begin
            set_config(OPEN_SEP_RST, CLOSE_SEP_RST, limits[i]);
            append("[ab  cd]");
            send_text();
            // Held spaces alone can fill the budget.
            append("[  x  y]");
            send_text();
            repeat (2)
            begin
                make_random_text(14);
                send_text();
            end
        end
        text_q.push_back(cfg_open);
        repeat (260)
            text_q.push_back(CH_SPACE);
        append("z]");
        send_text();
    endtask

    // Nesting right up to the limit closes cleanly; one level more is an error.
    task automatic test_nesting_limit();
        bit kinds[$];
        set_config(OPEN_SEP_RST, CLOSE_SEP_RST, 16'd0);
        text_q.push_back(cfg_open);
        repeat (NEST_LIMIT - 1)
        begin
            kinds.push_back(1'($urandom_range(0, 1)));
            text_q.push_back(kinds[$] ? cfg_open : CH_LPAR);
        end
        while (kinds.size() != 0)
            text_q.push_back(kinds.pop_back() ? cfg_close : CH_RPAR);
        append("] r");
        send_text();
        text_q.push_back(cfg_open);
        repeat (NEST_LIMIT)
            text_q.push_back($urandom_range(0, 1) ? cfg_open : CH_LPAR);
        append("ab");
        send_text();
    endtask

    // Random strings under a configuration that changes every few strings.
    task automatic test_random();
        logic [7:0]  open_c;
        logic [7:0]  close_c;
        logic [15:0] max_len;
        while (beats_sent < RANDOM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    open_c  = OPEN_SEP_RST;
                    close_c = CLOSE_SEP_RST;
                end
                1:
                begin
                    open_c  = 8'h7B;
                    close_c = 8'h7D;
                end
                2:
                begin
                    open_c  = 8'($urandom_range(0, 255));
                    close_c = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    open_c  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    close_c = ~open_c;
                end
            endcase
            case ($urandom_range(0, 3))
                0:       max_len = 16'd0;
                1:       max_len = 16'($urandom_range(1, 12));
                2:       max_len = 16'hFFFF;
                default: max_len = 16'($urandom_range(13, 40));
            endcase
            set_config(open_c, close_c, max_len);
            repeat (6)
            begin
                make_random_text(16);
                send_text();
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back-to-back beats, so the block has to fill up and stall its input.
    task automatic test_backpressure();
        int start;
        set_config(OPEN_SEP_RST, CLOSE_SEP_RST, 16'd0);
        holds_requested++;
        no_gaps = 1'b1;
        start = beats_sent;
        while (beats_sent - start < PRESSURE_BEATS)
        begin
            make_random_text(16);
            send_text();
        end
        no_gaps = 1'b0;
    endtask

    // Receiver. It stalls in a mode that is picked again at random when its run
    // ends: always ready, mostly ready, mostly stalled, or a repeating pattern taken
    // from a random byte. A hold request overrides the mode, for a hold set by HOLD_CYCLES.
    int         hold_left = 0;
    int         holds_done = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    int         pattern_pos = 0;
    logic [7:0] stall_pattern = '1;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (holds_done < holds_requested)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
                stall_pattern = 8'($urandom);
            end
            mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    m_tready <= stall_pattern[pattern_pos[2:0]];
                    pattern_pos++;
                end
            endcase
        end
    end

    // Result checker: every accepted result beat is compared field by field
    // with the oldest expectation. Only the first ten problems are printed.
    parse_result_t seen;
    parse_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind = m_tuser;
            seen.chr  = m_tdata[7:0];
            seen.lead = m_tdata[15:8];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d not expected: kind %0d char %02h lead %0d",
                             results_checked, seen.kind, seen.chr, seen.lead);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind || seen.chr !== want.chr
                    || seen.lead !== want.lead)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected kind %0d char %02h lead %0d, ",
                                  "got kind %0d char %02h lead %0d"},
                                 results_checked, want.kind, want.chr, want.lead,
                                 seen.kind, seen.chr, seen.lead);
                end
            end
            results_checked++;
        end
    end

    // Watchdog: counts cycles in which no beat moves on either stream.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        parser_restart();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_separators();
        test_truncation();
        test_nesting_limit();
        test_random();
        test_backpressure();

        // Drain, then wait on so that any stray result can still show up.
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
